/* rtl/qmrr_pkg.sv */
// ----------------------------------------------------------------------------
// qmrr_pkg
// Shared constants, codes and helpers for the queue mesh round-robin unit.
// ----------------------------------------------------------------------------
package qmrr_pkg;

    localparam int DEF_WRITERS    = 4;
    localparam int DEF_READERS    = 4;
    localparam int DEF_RING_DEPTH = 1024;

    localparam int CMD_W    = 2;
    localparam int PORT_W   = 2;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 3;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BCAST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

    // configuration register indexes
    localparam logic REG_WRITERS = 1'b0;
    localparam logic REG_READERS = 1'b1;

    // saturate a written count to 1..top
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                       input int top);
        logic [COUNT_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = COUNT_W'(1);
        end else if (int'(v) > top) begin
            res = COUNT_W'(top);
        end
        return res;
    endfunction

endpackage

/* rtl/queue_mesh_round_robin_unit.sv */
// ----------------------------------------------------------------------------
// queue_mesh_round_robin_unit
// Mesh of single-producer single-consumer rings held in one slot memory,
// driven by a small sequencer that touches one ring per step.
// ----------------------------------------------------------------------------
// sequence: a rejected item goes straight to the result register; a write
//   passes setup, address and check steps; a read does so for each writer ring
//   scanned; a broadcast checks every ring, then writes each one; one item at a time
// flow: a new item is taken only after the last result is loaded, later while a result waits
// reset: a clearing pass over all WRITERS*READERS*2**clog2(RING_DEPTH) slot addresses
//   zeroes every slot and ring pointer, input held off
// ----------------------------------------------------------------------------
module queue_mesh_round_robin_unit #(
    parameter int WRITERS    = qmrr_pkg::DEF_WRITERS,
    parameter int READERS    = qmrr_pkg::DEF_READERS,
    parameter int RING_DEPTH = qmrr_pkg::DEF_RING_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [qmrr_pkg::COUNT_W-1:0]     i_cfg_data,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [qmrr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // port[1:0], value[65:2], zero pad
    input  logic [qmrr_pkg::CMD_W-1:0]       s_axis_tuser,  // command[1:0]
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [qmrr_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // status[1:0], zero pad
);

    import qmrr_pkg::*;

    localparam int RING_COUNT = WRITERS * READERS;
    localparam int RW         = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
    localparam int SW         = $clog2(RING_DEPTH);
    localparam int AW         = RW + SW;
    localparam int MEM_DEPTH  = RING_COUNT * (2 ** SW);
    localparam int WIW        = (WRITERS > 1) ? $clog2(WRITERS) : 1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SETUP = 6'b000100,
        S_ADDR  = 6'b001000,
        S_CHK   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    function automatic logic [SW-1:0] bump(input logic [SW-1:0] p);
        return (p == SW'(RING_DEPTH - 1)) ? '0 : p + SW'(1);
    endfunction

    // port modulo count, port never above three
    function automatic logic [COUNT_W-1:0] mod_small(input logic [COUNT_W-1:0] v,
                                                     input logic [COUNT_W-1:0] m);
        logic [COUNT_W-1:0] t;
        t = v;
        for (int k = 0; k < 3; k++) begin
            if (t >= m) begin
                t = t - m;
            end
        end
        return t;
    endfunction

    // storage
    logic [VALUE_W-1:0] r_ring_mem [MEM_DEPTH];
    logic [SW-1:0]      r_wp_mem   [RING_COUNT];
    logic [SW-1:0]      r_rp_mem   [RING_COUNT];
    logic [COUNT_W-1:0] r_turn     [WRITERS];

    logic [VALUE_W-1:0] r_ring_q;
    logic [SW-1:0]      r_wp_q, r_rp_q;

    // control and item registers
    t_state              r_state, n_state;
    logic [AW-1:0]       r_sweep, n_sweep;
    logic [COUNT_W-1:0]  r_aw, r_ar;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [PORT_W-1:0]   r_port, n_port;
    logic [VALUE_W-1:0]  r_value, n_value;
    logic [RW-1:0]       r_ring, n_ring;
    logic [SW-1:0]       r_ptr, n_ptr;
    logic [COUNT_W-1:0]  r_idx, n_idx;
    logic [COUNT_W-1:0]  r_w, n_w;
    logic [COUNT_W-1:0]  r_tnext, n_tnext;
    logic                r_pass, n_pass;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_ovalid, n_ovalid;
    logic [STATUS_W-1:0] r_ostatus, n_ostatus;

    // memory port controls
    logic               ring_we;
    logic [AW-1:0]      ring_waddr, ring_raddr;
    logic [VALUE_W-1:0] ring_wdata;
    logic               wp_we, rp_we;
    logic [RW-1:0]      ptr_waddr;
    logic [SW-1:0]      ptr_wdata;
    logic               turn_we;
    logic [RW-1:0]      ring_c;

    logic [WIW-1:0]     widx;
    logic [COUNT_W-1:0] turn_fix;
    logic [COUNT_W-1:0] cw, cr;
    logic [6:0]         ring_full;
    logic [SW-1:0]      ptr_sel;
    logic [PORT_W-1:0]  in_port;
    logic [VALUE_W-1:0] in_value;
    logic               in_bad;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - STATUS_W){1'b0}}, r_ostatus};

    assign in_port  = s_axis_tdata[PORT_W-1:0];
    assign in_value = s_axis_tdata[PORT_W+VALUE_W-1:PORT_W];

    always_comb begin
        in_bad = 1'b0;
        if (s_axis_tuser == CMD_NONE) begin
            in_bad = 1'b1;
        end else if (s_axis_tuser == CMD_READ) begin
            in_bad = ({1'b0, in_port} >= r_ar);
        end else begin
            in_bad = ({1'b0, in_port} >= r_aw) || (in_value == '0);
        end
    end

    // ring number of the current step: writer * active_readers + reader
    assign widx     = WIW'(r_port);
    assign turn_fix = (r_turn[widx] >= r_ar) ? '0 : r_turn[widx];

    always_comb begin
        case (r_cmd)
            CMD_WRITE: begin
                cw = {1'b0, r_port};
                cr = turn_fix;
            end
            CMD_BCAST: begin
                cw = {1'b0, r_port};
                cr = r_idx;
            end
            default: begin
                cw = r_w;
                cr = {1'b0, r_port};
            end
        endcase
        ring_full = 7'(cw * r_ar) + 7'(cr);
        ring_c    = RW'(ring_full);
    end

    assign ptr_sel    = (r_cmd == CMD_READ) ? r_rp_q : r_wp_q;
    assign ring_raddr = {r_ring, ptr_sel};

    always_comb begin
        n_state   = r_state;
        n_sweep   = r_sweep;
        n_cmd     = r_cmd;
        n_port    = r_port;
        n_value   = r_value;
        n_ring    = r_ring;
        n_ptr     = r_ptr;
        n_idx     = r_idx;
        n_w       = r_w;
        n_tnext   = r_tnext;
        n_pass    = r_pass;
        n_status  = r_status;
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        ring_we    = 1'b0;
        ring_waddr = {r_ring, r_ptr};
        ring_wdata = r_value;
        wp_we      = 1'b0;
        rp_we      = 1'b0;
        ptr_waddr  = r_ring;
        ptr_wdata  = bump(r_ptr);
        turn_we    = 1'b0;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ring_we    = 1'b1;
                ring_waddr = r_sweep;
                ring_wdata = '0;
                wp_we      = 1'b1;
                rp_we      = 1'b1;
                ptr_waddr  = r_sweep[AW-1:SW];
                ptr_wdata  = '0;
                n_sweep    = r_sweep + AW'(1);
                if (r_sweep == AW'(MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd   = s_axis_tuser;
                    n_port  = in_port;
                    n_value = in_value;
                    n_idx   = '0;
                    n_pass  = 1'b0;
                    n_w     = mod_small({1'b0, in_port}, r_aw);
                    if (in_bad) begin
                        n_status = ST_BAD;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                // pointer memories read at ring_c this cycle
                n_ring  = ring_c;
                n_tnext = (turn_fix + COUNT_W'(1) >= r_ar) ? '0 : turn_fix + COUNT_W'(1);
                n_state = S_ADDR;
            end
            S_ADDR: begin
                n_ptr = ptr_sel;
                if (r_cmd == CMD_BCAST && r_pass) begin
                    ring_we    = 1'b1;
                    ring_waddr = {r_ring, ptr_sel};
                    wp_we      = 1'b1;
                    ptr_wdata  = bump(ptr_sel);
                    if (r_idx == r_ar - COUNT_W'(1)) begin
                        n_status = ST_DONE;
                        n_state  = S_DONE;
                    end else begin
                        n_idx   = r_idx + COUNT_W'(1);
                        n_state = S_SETUP;
                    end
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                case (r_cmd)
                    CMD_WRITE: begin
                        if (r_ring_q != '0) begin
                            n_status = ST_FULL;
                        end else begin
                            ring_we  = 1'b1;
                            wp_we    = 1'b1;
                            turn_we  = 1'b1;
                            n_status = ST_DONE;
                        end
                        n_state = S_DONE;
                    end
                    CMD_BCAST: begin
                        if (r_ring_q != '0) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else if (r_idx == r_ar - COUNT_W'(1)) begin
                            // every target has room, go back and fill them
                            n_pass  = 1'b1;
                            n_idx   = '0;
                            n_state = S_SETUP;
                        end else begin
                            n_idx   = r_idx + COUNT_W'(1);
                            n_state = S_SETUP;
                        end
                    end
                    default: begin
                        if (r_ring_q != '0) begin
                            ring_we    = 1'b1;
                            ring_wdata = '0;
                            rp_we      = 1'b1;
                            n_status   = ST_DONE;
                            n_state    = S_DONE;
                        end else if (r_idx == r_aw - COUNT_W'(1)) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_idx   = r_idx + COUNT_W'(1);
                            n_w     = (r_w + COUNT_W'(1) == r_aw) ? '0 : r_w + COUNT_W'(1);
                            n_state = S_SETUP;
                        end
                    end
                endcase
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring_mem[ring_waddr] <= ring_wdata;
        end
        r_ring_q <= r_ring_mem[ring_raddr];
    end

    // ring pointer memories
    always_ff @(posedge i_clk) begin
        if (wp_we) begin
            r_wp_mem[ptr_waddr] <= ptr_wdata;
        end
        if (rp_we) begin
            r_rp_mem[ptr_waddr] <= ptr_wdata;
        end
        r_wp_q <= r_wp_mem[ring_c];
        r_rp_q <= r_rp_mem[ring_c];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_sweep  <= '0;
            r_ovalid <= 1'b0;
            r_aw     <= clamp_count(COUNT_W'(4), WRITERS);
            r_ar     <= clamp_count(COUNT_W'(4), READERS);
            for (int k = 0; k < WRITERS; k++) begin
                r_turn[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_sweep  <= n_sweep;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_WRITERS: r_aw <= clamp_count(i_cfg_data, WRITERS);
                    REG_READERS: r_ar <= clamp_count(i_cfg_data, READERS);
                    default: ;
                endcase
            end
            if (turn_we) begin
                r_turn[widx] <= r_tnext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_port    <= n_port;
        r_value   <= n_value;
        r_ring    <= n_ring;
        r_ptr     <= n_ptr;
        r_idx     <= n_idx;
        r_w       <= n_w;
        r_tnext   <= n_tnext;
        r_pass    <= n_pass;
        r_status  <= n_status;
        r_ostatus <= n_ostatus;
    end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for queue_mesh_round_robin_unit. It sends write, broadcast and
// read commands on the input stream and keeps its own copy of the ring mesh.
// That copy gives the status of each command, and every returned status is
// checked in order. Runs change the active port counts, fill a ring until it
// is full, and idle or stall both streams at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qmrr_pkg::*;

    localparam int WRITERS          = DEF_WRITERS;
    localparam int READERS          = DEF_READERS;
    localparam int DEPTH            = DEF_RING_DEPTH;
    localparam int RINGS            = WRITERS * READERS;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int HOLD_CYCLES      = 300;
    localparam int ITEMS_PER_PHASE  = 12;
    localparam int TAIL_CYCLES      = 64;
    localparam int MAX_REPORTS      = 10;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_index   = REG_WRITERS;
    logic [COUNT_W-1:0]     i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [CMD_W-1:0]       s_axis_tuser  = CMD_WRITE;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // mesh copy used for prediction
    bit [VALUE_W-1:0] slot_word [RINGS][DEPTH];
    int unsigned      wr_pos [RINGS];
    int unsigned      rd_pos [RINGS];
    int unsigned      turn [WRITERS];
    int unsigned      n_writers = WRITERS;
    int unsigned      n_readers = READERS;

    logic [STATUS_W-1:0] status_due [$];

    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int sink_hold_len  = 0;
    int sink_hold_req  = 0;
    int sink_hold_seen = 0;
    int sink_hold_left = 0;

    int cycle_count     = 0;
    int mismatch_count  = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int cmd_count [4];
    int status_seen [4];

    queue_mesh_round_robin_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, status_due.size());
            $display("** queue_mesh_round_robin_unit: FAILED **");
            $finish;
        end
    end

    // status of one command, applied to the mesh copy
    function automatic logic [STATUS_W-1:0] apply_item(input logic [CMD_W-1:0]   cmd,
                                                       input logic [PORT_W-1:0]  port,
                                                       input logic [VALUE_W-1:0] value);
        int unsigned t;
        int unsigned ring;
        int unsigned w;
        int unsigned i;
        if (cmd == CMD_READ) begin
            if (port >= n_readers) return ST_BAD;
            for (i = 0; i < n_writers; i++) begin
                w = (i + port) % n_writers;
                ring = w * n_readers + port;
                if (slot_word[ring][rd_pos[ring]] != '0) begin
                    slot_word[ring][rd_pos[ring]] = '0;
                    rd_pos[ring] = (rd_pos[ring] + 1) % DEPTH;
                    return ST_DONE;
                end
            end
            return ST_EMPTY;
        end
        if (cmd == CMD_NONE || port >= n_writers || value == '0) return ST_BAD;
        if (cmd == CMD_WRITE) begin
            // a turn left over from a larger reader count falls back to reader zero
            t = (turn[port] >= n_readers) ? 0 : turn[port];
            ring = port * n_readers + t;
            if (slot_word[ring][wr_pos[ring]] != '0) return ST_FULL;
            slot_word[ring][wr_pos[ring]] = value;
            wr_pos[ring] = (wr_pos[ring] + 1) % DEPTH;
            turn[port] = (t + 1 >= n_readers) ? 0 : t + 1;
            return ST_DONE;
        end
        // broadcast is all or nothing
        for (i = 0; i < n_readers; i++) begin
            ring = port * n_readers + i;
            if (slot_word[ring][wr_pos[ring]] != '0) return ST_FULL;
        end
        for (i = 0; i < n_readers; i++) begin
            ring = port * n_readers + i;
            slot_word[ring][wr_pos[ring]] = value;
            wr_pos[ring] = (wr_pos[ring] + 1) % DEPTH;
        end
        return ST_DONE;
    endfunction

    function automatic logic [VALUE_W-1:0] nonzero_word();
        logic [VALUE_W-1:0] v;
        if ($urandom_range(0, 7) == 0) begin
            v = VALUE_W'($urandom_range(1, 255));
        end else begin
            v = {$urandom, $urandom};
        end
        if (v == '0) v = VALUE_W'(1);
        return v;
    endfunction

    // result side: random stalls, long hold-offs on request, in-order status check
    always @(posedge i_clk) begin : result_sink
        logic [STATUS_W-1:0] want;
        logic [STATUS_W-1:0] got;
        if (sink_hold_req != sink_hold_seen) begin
            sink_hold_seen = sink_hold_req;
            sink_hold_left = sink_hold_len;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[STATUS_W-1:0];
            status_seen[got]++;
            if (status_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result transaction: status %0d", got);
            end else begin
                want = status_due.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("status mismatch on result %0d: expected %0d, got %0d",
                                 results_checked, want, got);
                end
            end
            results_checked++;
        end
        if (sink_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    task automatic send_item(input logic [CMD_W-1:0]   cmd,
                             input logic [PORT_W-1:0]  port,
                             input logic [VALUE_W-1:0] value);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        status_due.insert(status_due.size(), apply_item(cmd, port, value));
        cmd_count[cmd]++;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - VALUE_W - PORT_W){1'b0}}, value, port};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (status_due.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [COUNT_W-1:0] data);
        int unsigned top;
        int unsigned cnt;
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        top = (idx == REG_WRITERS) ? WRITERS : READERS;
        cnt = (data == '0) ? 1 : ((data > top) ? top : data);
        if (idx == REG_WRITERS) n_writers = cnt;
        else n_readers = cnt;
        cfg_writes++;
    endtask

    task automatic test_basic_ops();
        send_item(CMD_READ,  2'd0, '0);
        send_item(CMD_WRITE, 2'd0, '1);
        send_item(CMD_WRITE, 2'd0, '0);
        send_item(CMD_BCAST, 2'd1, '0);
        send_item(CMD_NONE,  2'd3, nonzero_word());
        send_item(CMD_WRITE, 2'd3, VALUE_W'(1));
        send_item(CMD_BCAST, 2'd3, {1'b1, {(VALUE_W - 1){1'b0}}});
        send_item(CMD_READ,  2'd3, '1);
        send_item(CMD_READ,  2'd0, nonzero_word());
        send_item(CMD_READ,  2'd0, '0);
        send_item(CMD_READ,  2'd1, '0);
    endtask

    task automatic test_register_limits();
        // zero saturates to one port on each side
        write_reg(REG_WRITERS, 3'd0);
        write_reg(REG_READERS, 3'd0);
        send_item(CMD_WRITE, 2'd1, nonzero_word());
        send_item(CMD_READ,  2'd3, '0);
        send_item(CMD_BCAST, 2'd0, nonzero_word());
        send_item(CMD_READ,  2'd0, '1);
        write_reg(REG_WRITERS, 3'd7);
        write_reg(REG_READERS, 3'd7);
        repeat (3) send_item(CMD_WRITE, 2'd2, nonzero_word());
        // writer two now points past the new reader count
        write_reg(REG_READERS, 3'd2);
        send_item(CMD_WRITE, 2'd2, nonzero_word());
        send_item(CMD_READ,  2'd0, '0);
        send_item(CMD_READ,  2'd1, '0);
    endtask

    task automatic test_ring_full();
        write_reg(REG_WRITERS, 3'd1);
        write_reg(REG_READERS, 3'd1);
        // result side holds off while the input keeps offering
        sink_hold_len = HOLD_CYCLES;
        sink_hold_req++;
        repeat (DEPTH + 2) send_item(CMD_WRITE, 2'd0, nonzero_word());
        send_item(CMD_BCAST, 2'd0, nonzero_word());
        write_reg(REG_READERS, 3'd2);
        send_item(CMD_BCAST, 2'd0, nonzero_word());
        send_item(CMD_WRITE, 2'd0, nonzero_word());
        send_item(CMD_READ,  2'd0, '0);
        send_item(CMD_WRITE, 2'd0, nonzero_word());
        send_item(CMD_WRITE, 2'd0, nonzero_word());
        drain_results();
    endtask

    task automatic test_random_mix();
        logic [COUNT_W-1:0] phase_writers [8] = '{3'd4, 3'd1, 3'd7, 3'd2,
                                                  3'd3, 3'd0, 3'd4, 3'd6};
        logic [COUNT_W-1:0] phase_readers [8] = '{3'd4, 3'd4, 3'd1, 3'd3,
                                                  3'd2, 3'd1, 3'd5, 3'd2};
        int phase;
        int sent;
        int pick;
        int i;
        logic [CMD_W-1:0] cmd;
        for (phase = 0; phase < 8; phase++) begin
            write_reg(REG_WRITERS, phase_writers[phase]);
            write_reg(REG_READERS, phase_readers[phase]);
            case (phase % 4)
                0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_gap_pct = 52; sink_stall_pct = 0;  end
                2: begin src_gap_pct = 0;  sink_stall_pct = 52; end
                default: begin src_gap_pct = 35; sink_stall_pct = 35; end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    // one broadcast followed by a read from every active reader
                    send_item(CMD_BCAST, PORT_W'($urandom_range(0, n_writers - 1)),
                              nonzero_word());
                    for (i = 0; i < n_readers; i++)
                        send_item(CMD_READ, PORT_W'(i), {$urandom, $urandom});
                    sent += 1 + n_readers;
                end else begin
                    if (pick < 40) begin
                        send_item(CMD_WRITE, PORT_W'($urandom_range(0, n_writers - 1)),
                                  nonzero_word());
                    end else if (pick < 50) begin
                        send_item(CMD_BCAST, PORT_W'($urandom_range(0, n_writers - 1)),
                                  nonzero_word());
                    end else if (pick < 88) begin
                        send_item(CMD_READ, PORT_W'($urandom_range(0, n_readers - 1)),
                                  {$urandom, $urandom});
                    end else begin
                        // malformed items: zero words, stray ports, unused command
                        cmd = CMD_W'($urandom_range(0, 3));
                        if ($urandom_range(0, 1) == 0 && cmd != CMD_READ)
                            send_item(cmd, PORT_W'($urandom_range(0, 3)), '0);
                        else
                            send_item(cmd, PORT_W'($urandom_range(0, 3)), nonzero_word());
                    end
                    sent++;
                end
            end
        end
        src_gap_pct    = 0;
        sink_stall_pct = 0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_register_limits();
        test_ring_full();
        test_random_mix();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (status_due.size() != 0) begin
            $display("%0d expected results never arrived", status_due.size());
            mismatch_count += status_due.size();
        end
        $display("sent %0d writes, %0d broadcasts, %0d reads, %0d unused commands; %0d reg writes",
                 cmd_count[CMD_WRITE], cmd_count[CMD_BCAST], cmd_count[CMD_READ],
                 cmd_count[CMD_NONE], cfg_writes);
        $display("returned %0d done, %0d full, %0d empty, %0d rejected; %0d mismatches",
                 status_seen[ST_DONE], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_BAD], mismatch_count);
        if (mismatch_count == 0) begin
            $display("** queue_mesh_round_robin_unit: PASSED **");
        end else begin
            $display("** queue_mesh_round_robin_unit: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/qmrr_pkg.sv
rtl/queue_mesh_round_robin_unit.sv
dv/tb.sv
